// ===== rtl/core/sbus_remote_frame_decoder_top_macros.svh =====
// Assertion macros shared by the remote frame decoder RTL.
`ifndef SBUS_REMOTE_FRAME_DECODER_TOP_MACROS_SVH
`define SBUS_REMOTE_FRAME_DECODER_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SRFD_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication.
`define SRFD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/srfd_pkg.sv =====
// Package: widths, codes, reset values and scaling helper for the frame decoder.
package srfd_pkg;

   localparam int unsigned FRAME_BYTES_DEF = 25;
   localparam int unsigned PAYLOAD_BYTES   = 10;
   localparam int unsigned NUM_SLOTS       = 7;
   localparam int unsigned NUM_STICKS      = 4;
   localparam int unsigned NUM_AXES        = 5;
   localparam int unsigned WHEEL_SLOT      = 6;
   localparam int unsigned LEFT_SW_SLOT    = 4;
   localparam int unsigned RIGHT_SW_SLOT   = 5;
   localparam int unsigned OFFLINE_STICK   = 2;

   localparam int unsigned SLOT_W   = 11;
   localparam int unsigned CENT_W   = 12;
   localparam int unsigned AXIS_W   = 16;
   localparam int unsigned TICK_W   = 16;
   localparam int unsigned SCALE_W  = 22;
   localparam int unsigned DZ_W     = 8;
   localparam int unsigned SW_W     = 2;
   localparam int unsigned Q_SHIFT  = 16;
   localparam int unsigned PROD_W   = CENT_W + SCALE_W + 1;
   localparam int unsigned SHR_W    = PROD_W - Q_SHIFT;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 22;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BUS_MIN       = 3'd0,
      REG_BUS_MAX       = 3'd1,
      REG_DEAD_ZONE     = 3'd2,
      REG_OFFLINE_LIMIT = 3'd3,
      REG_SCALE_MULT    = 3'd4,
      REG_TIMEOUT_TICKS = 3'd5
   } csr_index_type;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [SW_W-1:0] SW_HIGH = 2'd1;
   localparam logic [SW_W-1:0] SW_MID  = 2'd2;
   localparam logic [SW_W-1:0] SW_LOW  = 2'd3;

   localparam logic [SLOT_W-1:0]  BUS_MIN_RST       = 11'd200;
   localparam logic [SLOT_W-1:0]  BUS_MAX_RST       = 11'd1800;
   localparam logic [DZ_W-1:0]    DEAD_ZONE_RST     = 8'd10;
   localparam logic [CENT_W-1:0]  OFFLINE_LIMIT_RST = 12'hC90;   // -880
   localparam logic [SCALE_W-1:0] SCALE_MULT_RST    = 22'd1342177;
   localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = 16'd100;

   localparam logic signed [SHR_W-1:0] AXIS_MAX = SHR_W'(32767);
   localparam logic signed [SHR_W-1:0] AXIS_MIN = -SHR_W'(32768);

   // Decoded frame (or timeout) waiting for the scaling stage.
   typedef struct packed {
      logic [NUM_AXES-1:0][CENT_W-1:0] axis;   // lanes 0..3 sticks, lane 4 wheel
      logic [SW_W-1:0]                 left_sw;
      logic [SW_W-1:0]                 right_sw;
      logic                            online;
      logic                            timed_out;
   } decode_type;

   // c * m / 2^16 rounded toward minus infinity, saturated to 16 bits.
   function automatic logic [AXIS_W-1:0] scale_sat(logic [CENT_W-1:0] c,
                                                   logic [SCALE_W-1:0] m);
      logic signed [PROD_W-1:0] prod;
      logic signed [SHR_W-1:0]  shr;
      prod = $signed(c) * $signed({1'b0, m});
      shr  = prod[PROD_W-1:Q_SHIFT];
      if (shr > AXIS_MAX) begin
         scale_sat = AXIS_MAX[AXIS_W-1:0];
      end else if (shr < AXIS_MIN) begin
         scale_sat = AXIS_MIN[AXIS_W-1:0];
      end else begin
         scale_sat = shr[AXIS_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/sbus_remote_frame_decoder_top.sv =====
// Remote-control serial frame decoder: byte window tracking, slot decode, scaling.
//
// Usage: feed one item per accepted req handshake, either a received byte
// (opcode 0, with line_idle marking the end of a burst) or one timer tick
// (opcode 1). A window closes on its FRAME_BYTES-th byte or on a byte flagged
// line_idle; only a window of exactly FRAME_BYTES bytes produces a result.
// Seven 11-bit slots are unpacked LSB first from window bytes 1..10: slots 0..3
// are sticks (centered, deadzoned, scaled to signed Q14), slot 6 is the wheel
// (centered and scaled, no deadzone), slots 4 and 5 are three-position
// switches. If timeout_ticks ticks pass without a window closing, a zeroed
// result with timed_out set is produced and the current window is dropped.
// Throughput is one item per clock while rsp_stall is low. A result is first
// registered in stage 1, which tracks the window, unpacks slots and centers
// them; the second stage runs the five 12x23 scaling
// multipliers in parallel and saturates into the output register. Both
// stages hold under rsp_stall; req_stall only rises when both are full and
// the output is stalled. Configuration goes through the csr write port and
// is to be changed only while no item is in flight.
`include "sbus_remote_frame_decoder_top_macros.svh"

module sbus_remote_frame_decoder_top #(
   parameter int unsigned FRAME_BYTES = srfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write_en,
   input  logic [srfd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [srfd_pkg::CSR_DATA_W-1:0]        csr_wdata,
   // input items
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic [7:0]                             req_data_byte,
   input  logic                                   req_line_idle,
   // result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [srfd_pkg::AXIS_W-1:0]     rsp_axis_slot0,
   output logic signed [srfd_pkg::AXIS_W-1:0]     rsp_axis_slot1,
   output logic signed [srfd_pkg::AXIS_W-1:0]     rsp_axis_slot2,
   output logic signed [srfd_pkg::AXIS_W-1:0]     rsp_axis_slot3,
   output logic signed [srfd_pkg::AXIS_W-1:0]     rsp_wheel_value,
   output logic [srfd_pkg::SW_W-1:0]              rsp_left_switch,
   output logic [srfd_pkg::SW_W-1:0]              rsp_right_switch,
   output logic                                   rsp_link_online,
   output logic                                   rsp_timed_out
);
   import srfd_pkg::*;

   localparam int unsigned POS_W  = $clog2(FRAME_BYTES + 1);
   localparam int unsigned ADDR_W = $clog2(PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES);
   localparam logic [POS_W-1:0] PAYLOAD_END = POS_W'(PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] POS_ONE     = POS_W'(1);

   // ---------------- configuration registers ----------------
   logic [SLOT_W-1:0]  bus_min_ff;
   logic [SLOT_W-1:0]  bus_max_ff;
   logic [DZ_W-1:0]    dead_zone_ff;
   logic [CENT_W-1:0]  offline_limit_ff;
   logic [SCALE_W-1:0] scale_mult_ff;
   logic [TICK_W-1:0]  timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_min_ff       <= BUS_MIN_RST;
         bus_max_ff       <= BUS_MAX_RST;
         dead_zone_ff     <= DEAD_ZONE_RST;
         offline_limit_ff <= OFFLINE_LIMIT_RST;
         scale_mult_ff    <= SCALE_MULT_RST;
         timeout_ff       <= TIMEOUT_TICKS_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_BUS_MIN:       bus_min_ff       <= csr_wdata[SLOT_W-1:0];
            REG_BUS_MAX:       bus_max_ff       <= csr_wdata[SLOT_W-1:0];
            REG_DEAD_ZONE:     dead_zone_ff     <= csr_wdata[DZ_W-1:0];
            REG_OFFLINE_LIMIT: offline_limit_ff <= csr_wdata[CENT_W-1:0];
            REG_SCALE_MULT:    scale_mult_ff    <= csr_wdata[SCALE_W-1:0];
            REG_TIMEOUT_TICKS: timeout_ff       <= csr_wdata[TICK_W-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // ---------------- handshake ----------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff;
   logic advance;
   logic req_accept;

   // Output register frees when empty or taken this cycle; stage 1 follows it.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // ---------------- window tracking ----------------
   logic [POS_W-1:0]  pos_ff, pos_in, pos_inc;
   logic [TICK_W-1:0] idle_ff, idle_in, tick_inc;
   logic              win_close, win_full, tick_fire, store_we, event_in;
   logic [ADDR_W-1:0] store_addr;
   logic [7:0]        payload_ff [PAYLOAD_BYTES];

   always_comb begin
      pos_inc    = pos_ff + POS_ONE;
      win_full   = (pos_inc == LAST_POS);
      win_close  = (pos_inc >= LAST_POS) || req_line_idle;
      tick_inc   = idle_ff + TICK_W'(1);
      // a wrapped counter or a zero limit fires too
      tick_fire  = (tick_inc == '0) || (tick_inc >= timeout_ff);
      store_we   = (pos_ff >= POS_ONE) && (pos_ff <= PAYLOAD_END);
      store_addr = ADDR_W'(pos_ff - POS_ONE);

      pos_in   = pos_ff;
      idle_in  = idle_ff;
      event_in = 1'b0;
      if (req_accept) begin
         if (req_opcode == OP_TICK) begin
            if (tick_fire) begin
               idle_in  = '0;
               pos_in   = '0;
               event_in = 1'b1;
            end else begin
               idle_in = tick_inc;
            end
         end else begin
            if (win_close) begin
               pos_in   = '0;
               idle_in  = '0;
               event_in = win_full;
            end else begin
               pos_in = pos_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         idle_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         idle_ff <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_opcode == OP_BYTE && store_we) begin
         payload_ff[store_addr] <= req_data_byte;
      end
   end

   // ---------------- slot unpack and centering ----------------
   logic [PAYLOAD_BYTES*8-1:0]    payload_vec;
   logic [NUM_SLOTS-1:0][SLOT_W-1:0] slot;
   logic [SLOT_W-1:0]             center;
   logic [NUM_AXES-1:0][CENT_W-1:0] cent;
   logic [CENT_W-1:0]             mag;
   decode_type                    frame_dec, s1_in, s1_ff;

   always_comb begin
      // the byte being stored now is passed through, so a window whose
      // closing byte is the last payload byte decodes it
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
         payload_vec[8*b +: 8] = (store_we && store_addr == ADDR_W'(b)) ? req_data_byte
                                                                         : payload_ff[b];
      end
      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot[k] = payload_vec[SLOT_W*k +: SLOT_W];
      end
   end

   always_comb begin
      center = SLOT_W'(({1'b0, bus_min_ff} + {1'b0, bus_max_ff}) >> 1);
      for (int k = 0; k < NUM_AXES; k++) begin
         cent[k] = {1'b0, slot[k]} - {1'b0, center};
      end
      // the wheel sits in slot 6, not slot 4
      cent[NUM_STICKS] = {1'b0, slot[WHEEL_SLOT]} - {1'b0, center};

      frame_dec = '0;
      for (int k = 0; k < NUM_STICKS; k++) begin
         mag = cent[k][CENT_W-1] ? -cent[k] : cent[k];
         frame_dec.axis[k] = (mag < {{(CENT_W-DZ_W){1'b0}}, dead_zone_ff}) ? '0 : cent[k];
      end
      frame_dec.axis[NUM_STICKS] = cent[NUM_STICKS];

      // tie order: low code, then center, then high code
      if (slot[LEFT_SW_SLOT] == bus_min_ff)      frame_dec.left_sw = SW_LOW;
      else if (slot[LEFT_SW_SLOT] == center)     frame_dec.left_sw = SW_MID;
      else if (slot[LEFT_SW_SLOT] == bus_max_ff) frame_dec.left_sw = SW_HIGH;
      else                                       frame_dec.left_sw = SW_LOW;

      if (slot[RIGHT_SW_SLOT] == bus_min_ff)      frame_dec.right_sw = SW_LOW;
      else if (slot[RIGHT_SW_SLOT] == center)     frame_dec.right_sw = SW_MID;
      else if (slot[RIGHT_SW_SLOT] == bus_max_ff) frame_dec.right_sw = SW_HIGH;
      else                                        frame_dec.right_sw = SW_LOW;

      frame_dec.online = !($signed(frame_dec.axis[OFFLINE_STICK]) <
                           $signed(offline_limit_ff));
      frame_dec.timed_out = 1'b0;
   end

   // ---------------- stage 1 register ----------------
   always_comb begin
      s1_in = s1_ff;
      if (event_in) begin
         if (req_opcode == OP_TICK) begin
            s1_in           = '0;
            s1_in.left_sw   = SW_LOW;
            s1_in.right_sw  = SW_LOW;
            s1_in.timed_out = 1'b1;
         end else begin
            s1_in = frame_dec;
         end
      end
      // event_in only happens when stage 1 is empty or moving on
      s1_valid_in = event_in || (s1_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // ---------------- scaling and output register ----------------
   logic [NUM_AXES-1:0][AXIS_W-1:0] axis_ff;
   logic [SW_W-1:0]                 left_sw_ff, right_sw_ff;
   logic                            online_ff, timed_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            axis_ff[k] <= scale_sat(s1_ff.axis[k], scale_mult_ff);
         end
         left_sw_ff   <= s1_ff.left_sw;
         right_sw_ff  <= s1_ff.right_sw;
         online_ff    <= s1_ff.online;
         timed_out_ff <= s1_ff.timed_out;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_axis_slot0   = axis_ff[0];
   assign rsp_axis_slot1   = axis_ff[1];
   assign rsp_axis_slot2   = axis_ff[2];
   assign rsp_axis_slot3   = axis_ff[3];
   assign rsp_wheel_value  = axis_ff[NUM_STICKS];
   assign rsp_left_switch  = left_sw_ff;
   assign rsp_right_switch = right_sw_ff;
   assign rsp_link_online  = online_ff;
   assign rsp_timed_out    = timed_out_ff;

   // ---------------- assertions ----------------
   logic tick_fire_acc, frame_full_acc, restarted, decoded, zeroed;

   assign tick_fire_acc  = req_accept && req_opcode == OP_TICK && tick_fire;
   assign frame_full_acc = req_accept && req_opcode == OP_BYTE && win_full;
   assign restarted      = idle_ff == '0 && pos_ff == '0 && s1_valid_ff && s1_ff.timed_out;
   assign decoded        = s1_valid_ff && !s1_ff.timed_out && pos_ff == '0;
   assign zeroed         = axis_ff == '0 && !online_ff && left_sw_ff == SW_LOW
                           && right_sw_ff == SW_LOW;

   `SRFD_ASSERT_HOLDS(a_pos_in_window, pos_ff < LAST_POS, "byte position past frame end")
   `SRFD_ASSERT_NEXT(a_timeout_restarts, tick_fire_acc, restarted, "timeout did not restart")
   `SRFD_ASSERT_NEXT(a_full_window_decodes, frame_full_acc, decoded, "full window not decoded")
   `SRFD_ASSERT_IMP(a_timeout_zeroed, rsp_valid_ff && timed_out_ff, zeroed, "timeout not zeroed")

endmodule
